// File: rtl/pcm_pkg.sv
// Shared constants, types and codes for the pin change monitor table.
`timescale 1ns / 1ps
package pcm_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int ANALOG_BASE = 54;
	localparam int FULL_SCALE  = 1023;

	localparam int PIN_W  = 7;
	localparam int VAL_W  = 10;
	localparam int KIND_W = 3;
	localparam int RCNT_W = 4;

	// table index and fill count widths
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [KIND_W-1:0] {
		REQ_ADD    = 3'd0,
		REQ_REMOVE = 3'd1,
		REQ_CLEAR  = 3'd2,
		REQ_LIST   = 3'd3,
		REQ_SAMPLE = 3'd4
	} req_kind_t;

	typedef enum logic [KIND_W-1:0] {
		RPT_CHANGE  = 3'd0,
		RPT_ADDED   = 3'd1,
		RPT_REMOVED = 3'd2,
		RPT_LISTED  = 3'd3,
		RPT_FULL    = 3'd4
	} rpt_kind_t;

	typedef struct packed {
		logic [PIN_W-1:0] pin;
		logic [VAL_W-1:0] sens;
		logic [VAL_W-1:0] last;
	} entry_t;

	// sequencer to ring: advance strobe and the entry entering the tail cell
	typedef struct packed {
		logic   shift;
		entry_t tail;
	} ring_ctl_t;

endpackage

// File: rtl/pcm_req_if.sv
// Request channel: one request to the monitor table.
`timescale 1ns / 1ps
interface pcm_req_if import pcm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] req_type;
	logic [PIN_W-1:0]  pin_id;
	logic              sens_given;
	logic [VAL_W-1:0]  sens_value;
	logic [VAL_W-1:0]  reading;

	modport source (output valid, req_type, pin_id, sens_given, sens_value, reading,
		input ready);
	modport sink (input valid, req_type, pin_id, sens_given, sens_value, reading,
		output ready);
endinterface

// File: rtl/pcm_rpt_if.sv
// Report channel: one report from the monitor table.
`timescale 1ns / 1ps
interface pcm_rpt_if import pcm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  report_kind;
	logic [PIN_W-1:0]   out_pin;
	logic [VAL_W-1:0]   out_value;
	logic [VAL_W-1:0]   out_sens;
	logic [RCNT_W-1:0]  entry_count;
	logic               last_of_run;

	modport source (output valid, report_kind, out_pin, out_value, out_sens,
		entry_count, last_of_run, input ready);
	modport sink (input valid, report_kind, out_pin, out_value, out_sens,
		entry_count, last_of_run, output ready);
endinterface

// File: rtl/pcm_cell.sv
// One table cell: holds an entry and takes its neighbor's entry on each advance.
`timescale 1ns / 1ps
module pcm_cell import pcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	input  entry_t    d,
	output entry_t    q
);

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

// File: rtl/pcm_seq.sv
// Sequencer: edits head, issues reports, steps the ring one entry per unstalled cycle.
`timescale 1ns / 1ps
module pcm_seq import pcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pcm_req_if.sink     req,
	pcm_rpt_if.source   rpt,
	input  entry_t      head,
	output ring_ctl_t   ctl
);

	typedef enum logic [1:0] {ST_IDLE, ST_PASS1, ST_PASS2} state_t;

	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
	localparam logic [VAL_W-1:0] FS_VAL   = VAL_W'(FULL_SCALE);

	state_t           state_q;
	req_kind_t        op_q;
	logic [PIN_W-1:0] pin_q;
	logic             given_q;
	logic [VAL_W-1:0] sval_q;
	logic [VAL_W-1:0] rd_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] n_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           rem_q;
	entry_t           tail_cap_q;

	logic              rvalid_q;
	rpt_kind_t         rkind_q;
	logic [PIN_W-1:0]  rpin_q;
	logic [VAL_W-1:0]  rval_q;
	logic [VAL_W-1:0]  rsens_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic              rlast_q;

	// head step decode
	logic [CNT_W-1:0] pos_n;
	logic             busy;
	logic             last_step;
	logic             in_range;
	logic             first;
	logic             out_free;
	logic             step;
	entry_t           wb;
	logic             emit;
	rpt_kind_t        e_kind;
	logic [PIN_W-1:0] e_pin;
	logic [VAL_W-1:0] e_val;
	logic [VAL_W-1:0] e_sens;
	logic [CNT_W-1:0] e_cnt;
	logic             e_last;
	logic             set_found;
	logic             cap_rem;
	logic             cap_tail;
	logic             n_upd;
	logic [CNT_W-1:0] n_nxt;
	logic [VAL_W-1:0] add_sens;

	// analog deadband
	logic [VAL_W-1:0] v_lo;
	logic [VAL_W-1:0] v_cl;
	logic [VAL_W:0]   hi_bound;
	logic [VAL_W:0]   v_plus;
	logic             chg;
	logic [VAL_W-1:0] v_new;

	assign pos_n     = CNT_W'(pos_q);
	assign busy      = (state_q != ST_IDLE);
	assign last_step = (pos_q == LAST_POS);
	assign in_range  = (pos_n < n_q);
	assign first     = in_range && (head.pin == pin_q) && !found_q;
	assign out_free  = !rvalid_q || rpt.ready;
	assign add_sens  = given_q ? sval_q : '0;

	assign v_lo     = (rd_q < head.sens) ? '0 : rd_q;
	assign v_cl     = (v_lo > (FS_VAL - head.sens)) ? FS_VAL : v_lo;
	assign hi_bound = {1'b0, head.last} + {1'b0, head.sens};
	assign v_plus   = {1'b0, v_cl} + {1'b0, head.sens};

	// analog pins take the clamped value, digital pins the raw reading
	always_comb begin
		if (pin_q >= PIN_W'(ANALOG_BASE)) begin
			chg   = ({1'b0, v_cl} > hi_bound) || (v_plus < {1'b0, head.last});
			v_new = v_cl;
		end else begin
			chg   = (rd_q != head.last);
			v_new = rd_q;
		end
	end

	always_comb begin
		wb        = head;
		emit      = 1'b0;
		e_kind    = RPT_CHANGE;
		e_pin     = head.pin;
		e_val     = head.last;
		e_sens    = head.sens;
		e_cnt     = n_q;
		e_last    = 1'b1;
		set_found = 1'b0;
		cap_rem   = 1'b0;
		cap_tail  = 1'b0;
		n_upd     = 1'b0;
		n_nxt     = n_q;
		case (op_q)
			REQ_ADD: begin
				if (first) begin
					set_found = 1'b1;
					if (given_q) begin
						wb.sens = sval_q;
					end
				end else if (!found_q && (pos_n == n_q)) begin
					wb.pin    = pin_q;
					wb.sens   = add_sens;
					wb.last   = '0;
					set_found = 1'b1;
					emit      = 1'b1;
					e_kind    = RPT_ADDED;
					e_pin     = pin_q;
					e_val     = '0;
					e_sens    = add_sens;
					e_cnt     = n_q + ONE_CNT;
					n_upd     = 1'b1;
					n_nxt     = n_q + ONE_CNT;
				end else if (!found_q && last_step && (n_q == FULL_CNT)) begin
					emit   = 1'b1;
					e_kind = RPT_FULL;
					e_pin  = pin_q;
					e_val  = '0;
					e_sens = '0;
				end
			end
			REQ_REMOVE: begin
				if (state_q == ST_PASS1) begin
					if (first) begin
						set_found = 1'b1;
						cap_rem   = 1'b1;
					end
					// last entry is saved and cleared once the match is known
					if ((n_q != '0) && (pos_n == n_q - ONE_CNT) && (found_q || first)) begin
						cap_tail = 1'b1;
						wb       = '0;
					end
				end else if (pos_q == idx_q) begin
					if (CNT_W'(idx_q) != n_q - ONE_CNT) begin
						wb = tail_cap_q;
					end
					emit   = 1'b1;
					e_kind = RPT_REMOVED;
					e_pin  = rem_q.pin;
					e_val  = rem_q.last;
					e_sens = rem_q.sens;
					e_cnt  = n_q - ONE_CNT;
					n_upd  = 1'b1;
					n_nxt  = n_q - ONE_CNT;
				end
			end
			REQ_CLEAR: begin
				if (in_range) begin
					wb     = '0;
					emit   = 1'b1;
					e_kind = RPT_REMOVED;
					e_cnt  = n_q - pos_n - ONE_CNT;
					e_last = (pos_n == n_q - ONE_CNT);
				end
				if (last_step) begin
					n_upd = 1'b1;
					n_nxt = '0;
				end
			end
			REQ_LIST: begin
				if (in_range) begin
					emit   = 1'b1;
					e_kind = RPT_LISTED;
					e_last = (pos_n == n_q - ONE_CNT);
				end
			end
			REQ_SAMPLE: begin
				if (first && (pin_q != '0)) begin
					set_found = 1'b1;
					if (chg) begin
						wb.last = v_new;
						emit    = 1'b1;
						e_kind  = RPT_CHANGE;
						e_pin   = pin_q;
						e_val   = v_new;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign step      = busy && (!emit || out_free);
	assign ctl.shift = step;
	assign ctl.tail  = wb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			n_q      <= '0;
			found_q  <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (rvalid_q && rpt.ready) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q    <= req_kind_t'(req.req_type);
						pin_q   <= req.pin_id;
						given_q <= req.sens_given;
						sval_q  <= req.sens_value;
						rd_q    <= req.reading;
						found_q <= 1'b0;
						pos_q   <= '0;
						if (req.req_type <= KIND_W'(REQ_SAMPLE)) begin
							state_q <= ST_PASS1;
						end
					end
				end
				ST_PASS1, ST_PASS2: begin
					if (step) begin
						pos_q <= last_step ? '0 : pos_q + IDX_W'(1);
						if (set_found) begin
							found_q <= 1'b1;
							idx_q   <= pos_q;
						end
						if (cap_rem) begin
							rem_q <= head;
						end
						if (cap_tail) begin
							tail_cap_q <= head;
						end
						if (n_upd) begin
							n_q <= n_nxt;
						end
						if (emit) begin
							rvalid_q <= 1'b1;
							rkind_q  <= e_kind;
							rpin_q   <= e_pin;
							rval_q   <= e_val;
							rsens_q  <= e_sens;
							rcnt_q   <= RCNT_W'(e_cnt);
							rlast_q  <= e_last;
						end
						if (last_step) begin
							if ((state_q == ST_PASS1) && (op_q == REQ_REMOVE) &&
								(found_q || set_found)) begin
								state_q <= ST_PASS2;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rpt.valid       = rvalid_q;
	assign rpt.report_kind = rkind_q;
	assign rpt.out_pin     = rpin_q;
	assign rpt.out_value   = rval_q;
	assign rpt.out_sens    = rsens_q;
	assign rpt.entry_count = rcnt_q;
	assign rpt.last_of_run = rlast_q;

	// ring stays aligned between requests
	a_aligned_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (pos_q == '0))
		else $error("ring not aligned while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FULL_CNT)
		else $error("entry count above table size");

	a_pass2_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS2) |-> (found_q && (op_q == REQ_REMOVE)))
		else $error("swap pass without a matched entry");

	a_full_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit && (e_kind == RPT_FULL)) |-> (n_q == FULL_CNT))
		else $error("table full report while space remains");

	a_blocked_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && emit && !out_free) |=> $stable(pos_q))
		else $error("ring advanced while report slot was busy");

endmodule

// File: rtl/pin_change_monitor_table.sv
// Top level of the pin change monitor table: ring of entry cells plus sequencer.
`timescale 1ns / 1ps
// A request walks the whole ring once, one advance per table entry; a remove that
//   hits walks it twice; a request of an unknown type is taken with no walk.
// A new request is taken only while idle; the idle step that takes it is not
//   overlapped with the walk. A report that waits on the report channel freezes the
//   ring until the report slot frees up.
// Reports leave from a one-deep output register, so the first report of a request
//   shows up the cycle after its head step.
// Reset: arst_n clears every cell and the count; the table comes up empty, no sweep.
module pin_change_monitor_table import pcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	pcm_req_if.sink   req,
	pcm_rpt_if.source rpt
);

	// cell 0 is the head the sequencer looks at; cell MAX_ENTRIES-1 takes the
	// edited head entry back in, so one advance rotates the table by one slot
	// and a full pass brings every entry back to its own table index.
	entry_t    cell_q [MAX_ENTRIES];
	ring_ctl_t ctl;

	for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
		if (k == MAX_ENTRIES - 1) begin : g_tail
			pcm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (ctl.tail),
				.q      (cell_q[k])
			);
		end else begin : g_body
			pcm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.d      (cell_q[k+1]),
				.q      (cell_q[k])
			);
		end
	end

	// sequencer: add/remove/clear/list/sample decode at the head, report register
	pcm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rpt    (rpt),
		.head   (cell_q[0]),
		.ctl    (ctl)
	);

endmodule
